// File: src/ebalu_pkg.sv
// Shared types, operation codes and constants for the eight-bit ALU with flags.
`default_nettype none

package ebalu_pkg;

  // Operation codes on the kind field
  localparam logic [4:0] KIND_ADD  = 5'd0;
  localparam logic [4:0] KIND_ADC  = 5'd1;
  localparam logic [4:0] KIND_SUB  = 5'd2;
  localparam logic [4:0] KIND_SBC  = 5'd3;
  localparam logic [4:0] KIND_AND  = 5'd4;
  localparam logic [4:0] KIND_XOR  = 5'd5;
  localparam logic [4:0] KIND_OR   = 5'd6;
  localparam logic [4:0] KIND_CP   = 5'd7;
  localparam logic [4:0] KIND_INC  = 5'd8;
  localparam logic [4:0] KIND_DEC  = 5'd9;
  localparam logic [4:0] KIND_DAA  = 5'd10;
  localparam logic [4:0] KIND_CPL  = 5'd11;
  localparam logic [4:0] KIND_SCF  = 5'd12;
  localparam logic [4:0] KIND_CCF  = 5'd13;
  localparam logic [4:0] KIND_RLCA = 5'd14;
  localparam logic [4:0] KIND_RRCA = 5'd15;
  localparam logic [4:0] KIND_RLA  = 5'd16;
  localparam logic [4:0] KIND_RRA  = 5'd17;
  localparam logic [4:0] KIND_PFX  = 5'd18;

  // Prefix byte groups (bits 7..6)
  localparam logic [1:0] GRP_SHIFT = 2'd0;
  localparam logic [1:0] GRP_BIT   = 2'd1;
  localparam logic [1:0] GRP_RES   = 2'd2;
  localparam logic [1:0] GRP_SET   = 2'd3;

  // Rotate and shift kinds in the shift group (bits 5..3)
  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_SWAP = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  // Decimal adjust constants
  localparam logic [7:0] DAA_ADJ_LO = 8'h06;
  localparam logic [7:0] DAA_ADJ_HI = 8'h60;
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [3:0] NIB_LIMIT  = 4'd9;

  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } ebalu_flags_t;

  typedef struct packed {
    logic [4:0]   kind;
    logic [7:0]   a;
    logic [7:0]   b;
    ebalu_flags_t flags;
  } ebalu_req_t;

  typedef struct packed {
    logic [7:0]   result;
    logic         wb;
    ebalu_flags_t flags;
  } ebalu_res_t;

endpackage

`default_nettype wire

// File: src/ebalu_cb.sv
// Prefixed bit unit: rotates, shifts, swap, bit test, bit reset and bit set.
`default_nettype none

module ebalu_cb (
  input  wire logic [7:0]            a,
  input  wire logic [7:0]            op,
  input  wire ebalu_pkg::ebalu_flags_t flags_in,
  output ebalu_pkg::ebalu_res_t      res
);

  logic [1:0] grp;
  logic [2:0] sel;
  logic [7:0] mask;
  logic [7:0] sh_r;
  logic       sh_c;

  assign grp  = op[7:6];
  assign sel  = op[5:3];
  assign mask = 8'b1 << sel;

  // Pick the rotate or shift result and its carry
  always_comb begin
    unique case (sel)
      ebalu_pkg::SH_RLC:  begin sh_c = a[7]; sh_r = {a[6:0], a[7]};         end
      ebalu_pkg::SH_RRC:  begin sh_c = a[0]; sh_r = {a[0], a[7:1]};         end
      ebalu_pkg::SH_RL:   begin sh_c = a[7]; sh_r = {a[6:0], flags_in.c};   end
      ebalu_pkg::SH_RR:   begin sh_c = a[0]; sh_r = {flags_in.c, a[7:1]};   end
      ebalu_pkg::SH_SLA:  begin sh_c = a[7]; sh_r = {a[6:0], 1'b0};         end
      ebalu_pkg::SH_SRA:  begin sh_c = a[0]; sh_r = {a[7], a[7:1]};         end
      ebalu_pkg::SH_SWAP: begin sh_c = 1'b0; sh_r = {a[3:0], a[7:4]};       end
      ebalu_pkg::SH_SRL:  begin sh_c = a[0]; sh_r = {1'b0, a[7:1]};         end
      default:            begin sh_c = a[0]; sh_r = a;                      end
    endcase
  end

  // Select by group; reset and set leave the flags alone
  always_comb begin
    res.result = a;
    res.wb     = 1'b1;
    res.flags  = flags_in;
    unique case (grp)
      ebalu_pkg::GRP_SHIFT: begin
        res.result  = sh_r;
        res.flags.z = (sh_r == 8'd0);
        res.flags.n = 1'b0;
        res.flags.h = 1'b0;
        res.flags.c = sh_c;
      end
      ebalu_pkg::GRP_BIT: begin
        res.wb      = 1'b0;
        res.flags.z = ~a[sel];
        res.flags.n = 1'b0;
        res.flags.h = 1'b1;
      end
      ebalu_pkg::GRP_RES: res.result = a & ~mask;
      ebalu_pkg::GRP_SET: res.result = a | mask;
      default:            res.result = a;
    endcase
  end

endmodule

`default_nettype wire

// File: src/ebalu_core.sv
// Single-pass ALU logic: arithmetic, logic, decimal adjust, rotates and flags.
`default_nettype none

module ebalu_core (
  input  wire ebalu_pkg::ebalu_req_t req,
  output ebalu_pkg::ebalu_res_t      res
);

  logic                  add_cin;
  logic                  sub_cin;
  logic [8:0]            add_sum;
  logic [4:0]            add_half;
  logic [8:0]            sub_diff;
  logic [4:0]            sub_half;
  logic [7:0]            inc_val;
  logic [7:0]            dec_val;
  logic                  daa_lo;
  logic                  daa_hi;
  logic [7:0]            daa_adj;
  logic [7:0]            daa_val;
  ebalu_pkg::ebalu_res_t cb_res;

  // Carry and borrow in for the with-carry forms
  assign add_cin = (req.kind == ebalu_pkg::KIND_ADC) & req.flags.c;
  assign sub_cin = (req.kind == ebalu_pkg::KIND_SBC) & req.flags.c;

  assign add_sum  = {1'b0, req.a} + {1'b0, req.b} + {8'd0, add_cin};
  assign add_half = {1'b0, req.a[3:0]} + {1'b0, req.b[3:0]} + {4'd0, add_cin};
  assign sub_diff = {1'b0, req.a} - {1'b0, req.b} - {8'd0, sub_cin};
  assign sub_half = {1'b0, req.a[3:0]} - {1'b0, req.b[3:0]} - {4'd0, sub_cin};
  assign inc_val  = req.a + 8'd1;
  assign dec_val  = req.a - 8'd1;

  // Decimal adjust correction
  assign daa_lo  = req.flags.h | (~req.flags.n & (req.a[3:0] > ebalu_pkg::NIB_LIMIT));
  assign daa_hi  = req.flags.c | (~req.flags.n & (req.a > ebalu_pkg::DAA_LIMIT));
  assign daa_adj = (daa_lo ? ebalu_pkg::DAA_ADJ_LO : 8'd0) |
                   (daa_hi ? ebalu_pkg::DAA_ADJ_HI : 8'd0);
  assign daa_val = req.flags.n ? (req.a - daa_adj) : (req.a + daa_adj);

  ebalu_cb u_cb (
    .a        (req.a),
    .op       (req.b),
    .flags_in (req.flags),
    .res      (cb_res)
  );

  // Select result and flags by operation
  always_comb begin
    res.result = req.a;
    res.wb     = 1'b0;
    res.flags  = req.flags;
    unique case (req.kind)
      ebalu_pkg::KIND_ADD, ebalu_pkg::KIND_ADC: begin
        res.result  = add_sum[7:0];
        res.wb      = 1'b1;
        res.flags.z = (add_sum[7:0] == 8'd0);
        res.flags.n = 1'b0;
        res.flags.h = add_half[4];
        res.flags.c = add_sum[8];
      end
      ebalu_pkg::KIND_SUB, ebalu_pkg::KIND_SBC, ebalu_pkg::KIND_CP: begin
        res.result  = sub_diff[7:0];
        res.wb      = (req.kind != ebalu_pkg::KIND_CP);
        res.flags.z = (sub_diff[7:0] == 8'd0);
        res.flags.n = 1'b1;
        res.flags.h = sub_half[4];
        res.flags.c = sub_diff[8];
      end
      ebalu_pkg::KIND_AND: begin
        res.result = req.a & req.b;
        res.wb     = 1'b1;
        res.flags  = '{z: ((req.a & req.b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ebalu_pkg::KIND_XOR: begin
        res.result = req.a ^ req.b;
        res.wb     = 1'b1;
        res.flags  = '{z: ((req.a ^ req.b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ebalu_pkg::KIND_OR: begin
        res.result = req.a | req.b;
        res.wb     = 1'b1;
        res.flags  = '{z: ((req.a | req.b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ebalu_pkg::KIND_INC: begin
        res.result  = inc_val;
        res.wb      = 1'b1;
        res.flags.z = (inc_val == 8'd0);
        res.flags.n = 1'b0;
        res.flags.h = (inc_val[3:0] == 4'h0);
      end
      ebalu_pkg::KIND_DEC: begin
        res.result  = dec_val;
        res.wb      = 1'b1;
        res.flags.z = (dec_val == 8'd0);
        res.flags.n = 1'b1;
        res.flags.h = (dec_val[3:0] == 4'hF);
      end
      ebalu_pkg::KIND_DAA: begin
        res.result  = daa_val;
        res.wb      = 1'b1;
        res.flags.z = (daa_val == 8'd0);
        res.flags.h = 1'b0;
        res.flags.c = daa_hi;
      end
      ebalu_pkg::KIND_CPL: begin
        res.result  = ~req.a;
        res.wb      = 1'b1;
        res.flags.n = 1'b1;
        res.flags.h = 1'b1;
      end
      ebalu_pkg::KIND_SCF: begin
        res.flags.n = 1'b0;
        res.flags.h = 1'b0;
        res.flags.c = 1'b1;
      end
      ebalu_pkg::KIND_CCF: begin
        res.flags.n = 1'b0;
        res.flags.h = 1'b0;
        res.flags.c = ~req.flags.c;
      end
      ebalu_pkg::KIND_RLCA: begin
        res.result = {req.a[6:0], req.a[7]};
        res.wb     = 1'b1;
        res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: req.a[7]};
      end
      ebalu_pkg::KIND_RRCA: begin
        res.result = {req.a[0], req.a[7:1]};
        res.wb     = 1'b1;
        res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: req.a[0]};
      end
      ebalu_pkg::KIND_RLA: begin
        res.result = {req.a[6:0], req.flags.c};
        res.wb     = 1'b1;
        res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: req.a[7]};
      end
      ebalu_pkg::KIND_RRA: begin
        res.result = {req.flags.c, req.a[7:1]};
        res.wb     = 1'b1;
        res.flags  = '{z: 1'b0, n: 1'b0, h: 1'b0, c: req.a[0]};
      end
      ebalu_pkg::KIND_PFX: res = cb_res;
      default: begin
        // unused codes: no operation, flags pass through
        res.result = req.a;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/eight_bit_alu_with_flags_top.sv
// Top level of the eight-bit ALU with flags: input register, ALU logic, result register.
`default_nettype none

// Eight-bit ALU with Z/N/H/C flags. Each input word carries an operation code, two
// operand bytes and the current flags; it produces one result word with the new byte,
// a write-back bit and the new flags. The block takes one word every clock cycle while
// the output is not stalled. Each accepted word is held first in the input register and
// then in the result register, with the whole ALU evaluated in a single pass between
// them. A stalled output holds its word; the input stays ready as long as either
// register has room or the output is being taken. There is no state between words and
// nothing to configure.
module eight_bit_alu_with_flags_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [4:0] in_kind,
  input  wire logic [7:0] in_operand_a,
  input  wire logic [7:0] in_operand_b,
  input  wire logic       in_flag_z_in,
  input  wire logic       in_flag_n_in,
  input  wire logic       in_flag_h_in,
  input  wire logic       in_flag_c_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_result,
  output logic            out_write_back,
  output logic            out_flag_z_out,
  output logic            out_flag_n_out,
  output logic            out_flag_h_out,
  output logic            out_flag_c_out
);

  ebalu_pkg::ebalu_req_t req_r;
  ebalu_pkg::ebalu_res_t res_r;
  ebalu_pkg::ebalu_res_t res_nxt;
  logic                  req_vld_r;
  logic                  res_vld_r;
  logic                  res_load;
  logic                  req_load;

  // Advance when the next stage has room or is draining
  assign res_load = ~res_vld_r | out_ready;
  assign in_ready = ~req_vld_r | res_load;
  assign req_load = in_valid & in_ready;

  // Hold valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (in_ready) req_vld_r <= in_valid;
      if (res_load) res_vld_r <= req_vld_r;
    end
  end

  // Capture the input word
  always_ff @(posedge clk) begin
    if (req_load) begin
      req_r.kind    <= in_kind;
      req_r.a       <= in_operand_a;
      req_r.b       <= in_operand_b;
      req_r.flags.z <= in_flag_z_in;
      req_r.flags.n <= in_flag_n_in;
      req_r.flags.h <= in_flag_h_in;
      req_r.flags.c <= in_flag_c_in;
    end
  end

  ebalu_core u_core (
    .req (req_r),
    .res (res_nxt)
  );

  // Capture the result word
  always_ff @(posedge clk) begin
    if (res_load && req_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = res_vld_r;
  assign out_result     = res_r.result;
  assign out_write_back = res_r.wb;
  assign out_flag_z_out = res_r.flags.z;
  assign out_flag_n_out = res_r.flags.n;
  assign out_flag_h_out = res_r.flags.h;
  assign out_flag_c_out = res_r.flags.c;

endmodule

`default_nettype wire

// File: src/ebalu_chk.sv
// Port-level checker for the eight-bit ALU top, attached by bind.
`default_nettype none

module ebalu_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_result,
  input wire logic       out_write_back
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A draining output never stalls the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled while output can move");

  // A stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_write_back))
    else $error("stalled result word changed");

  // Valid drops only after a transfer
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result word dropped without transfer");

endmodule

bind eight_bit_alu_with_flags_top ebalu_chk u_ebalu_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_result     (out_result),
  .out_write_back (out_write_back)
);

`default_nettype wire
